FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/kip_pkg.sv
// Package with the constants, codes and interface types of the position lookup.
package kip_pkg;

    // Default sizes of the sample tables.
    localparam int PLAYERS_DEF   = 16;
    localparam int SAMPLES_DEF   = 256;
    localparam int NEIGHBORS_DEF = 5;

    // Datapath widths.
    localparam int COORD_W  = 16;
    localparam int DIST_W   = 36;
    localparam int LOG_W    = 22;
    localparam int NEXP_W   = 6;
    localparam int MANT_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int WEXP_W   = 7;
    localparam int WT_W     = 32;
    localparam int POW_W    = 18;
    localparam int GVAL_W   = 17;
    localparam int KEXP_W   = 9;
    localparam int MUL_W    = 33;
    localparam int NUM_W    = 50;
    localparam int DEN_W    = 34;
    localparam int REM_W    = 52;
    localparam int QUO_W    = 17;
    localparam int LOG_STEPS = 16;

    // Distance limits in squared Q8.8 units.
    localparam logic [DIST_W-1:0] FAR_D2      = 36'd65536000000;
    localparam logic [DIST_W-1:0] NEAR_D2_MIN = 36'd7;

    // Configuration reset value.
    localparam logic [WEXP_W-1:0] WEXP_RESET = 7'd16;

    // Item modes.
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [1:0] MODE_NEAREST  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_STORED  = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_ANSWER  = 2'd2;

    // Cubic for 2^x on [0,1] in Q16, highest order first.
    localparam logic [POW_W-1:0] EXP_C3 = 18'd5148;
    localparam logic [POW_W-1:0] EXP_C2 = 18'd14829;
    localparam logic [POW_W-1:0] EXP_C1 = 18'd45559;
    localparam logic [POW_W-1:0] EXP_C0 = 18'd65536;

    // Saturation of the answer.
    localparam logic [QUO_W-1:0] QUO_SAT = 17'd32768;
    localparam logic signed [QUO_W:0] POS_MAX = 18'sd32767;

    // Request to the divider.
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    // Answer of the divider.
    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: hw/rtl/kip_div.sv
// Restoring divider: rounded signed quotient num/den, one quotient bit per cycle.
module kip_div (
    input  logic              clk,
    input  logic              rst_n,
    input  kip_pkg::div_req_t req,
    output kip_pkg::div_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       neg_reg, neg_next;
    logic [kip_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [kip_pkg::REM_W-1:0]  dvs_reg, dvs_next;
    logic [kip_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [4:0]                 step_reg, step_next;
    logic [kip_pkg::NUM_W-1:0]  mag;
    logic [kip_pkg::QUO_W-1:0]  quo_sat;
    logic signed [kip_pkg::QUO_W:0] quo_signed;

    // Start loads 2*|num|+den over 2*den; each step retires one quotient bit.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        mag       = req.num[kip_pkg::NUM_W-1] ? kip_pkg::NUM_W'(-req.num)
                                              : kip_pkg::NUM_W'(req.num);
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.num[kip_pkg::NUM_W-1];
            rem_next  = kip_pkg::REM_W'({mag, 1'b0}) + kip_pkg::REM_W'(req.den);
            dvs_next  = kip_pkg::REM_W'({req.den, {kip_pkg::QUO_W{1'b0}}});
            quo_next  = '0;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[kip_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[kip_pkg::QUO_W-2:0], 1'b0};
            end
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(kip_pkg::QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Saturate and apply the sign.
    always_comb
    begin
        quo_sat    = (quo_reg > kip_pkg::QUO_SAT) ? kip_pkg::QUO_SAT : quo_reg;
        quo_signed = neg_reg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
        rsp.done   = done_reg;
        rsp.quot   = (quo_signed > kip_pkg::POS_MAX) ? kip_pkg::COORD_W'(kip_pkg::POS_MAX)
                                                     : quo_signed[kip_pkg::COORD_W-1:0];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

endmodule

FILE: hw/rtl/knn_idw_position_lookup.sv
// Per-player position lookup by nearest-neighbor inverse-distance weighting.
// A load writes its sample and goes straight to the result. A nearest query scans every
// stored sample of the player. A weighted query scans every stored sample, then for each
// neighbor normalizes the distance and takes its log, then computes each weight, then runs
// two divisions, x first. The single shared 33x33 multiplier, used once per cycle for
// squares, log steps, the power cubic and the weighted sums, and the one-read-per-cycle
// sample memory set the pace. The block takes one item at a time; the finished result sits
// in an output register, so the next item is taken while it waits. The sample memory needs
// no clearing.
module knn_idw_position_lookup #(
    parameter int PLAYERS   = kip_pkg::PLAYERS_DEF,
    parameter int SAMPLES   = kip_pkg::SAMPLES_DEF,
    parameter int NEIGHBORS = kip_pkg::NEIGHBORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kip_pkg::WEXP_W-1:0]          weight_exponent,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          mode,
    input  logic [3:0]                          player,
    input  logic signed [kip_pkg::COORD_W-1:0]  ball_x,
    input  logic signed [kip_pkg::COORD_W-1:0]  ball_y,
    input  logic signed [kip_pkg::COORD_W-1:0]  target_x,
    input  logic signed [kip_pkg::COORD_W-1:0]  target_y,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          status,
    output logic signed [kip_pkg::COORD_W-1:0]  pos_x,
    output logic signed [kip_pkg::COORD_W-1:0]  pos_y
);

    localparam int PW  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
    localparam int SW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int AW  = PW + SW;
    localparam int CW  = $clog2(SAMPLES + 1);
    localparam int SLW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int DW  = kip_pkg::DIST_W;
    localparam int CRW = kip_pkg::COORD_W;
    localparam int MW  = kip_pkg::MUL_W;

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SC_DX    = 5'd1;
    localparam logic [4:0] S_SC_DY    = 5'd2;
    localparam logic [4:0] S_SC_INS   = 5'd3;
    localparam logic [4:0] S_POST     = 5'd4;
    localparam logic [4:0] S_LG_INIT  = 5'd5;
    localparam logic [4:0] S_LG_NORM  = 5'd6;
    localparam logic [4:0] S_LG_SQ    = 5'd7;
    localparam logic [4:0] S_LG_CHK   = 5'd8;
    localparam logic [4:0] S_WT_N     = 5'd9;
    localparam logic [4:0] S_WT_G     = 5'd10;
    localparam logic [4:0] S_WT_HM    = 5'd11;
    localparam logic [4:0] S_WT_HA    = 5'd12;
    localparam logic [4:0] S_WT_SH    = 5'd13;
    localparam logic [4:0] S_WT_MX    = 5'd14;
    localparam logic [4:0] S_WT_MY    = 5'd15;
    localparam logic [4:0] S_WT_AY    = 5'd16;
    localparam logic [4:0] S_DIV_GO   = 5'd17;
    localparam logic [4:0] S_DIV_WAIT = 5'd18;
    localparam logic [4:0] S_FIN      = 5'd19;

    // Sample memory and its read register.
    logic [4*CRW-1:0] mem [MEM_DEPTH];
    logic [4*CRW-1:0] rd_word_reg;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [4*CRW-1:0] wr_word;
    logic             mem_we;

    // Control registers.
    logic [4:0]                st_reg, st_next;
    logic [CW-1:0]             count_reg [PLAYERS];
    logic [CW-1:0]             count_next [PLAYERS];
    logic [kip_pkg::WEXP_W-1:0] wexp_reg, wexp_next;
    logic                      out_valid_reg, out_valid_next;

    // Item and scan registers.
    logic [1:0]                mode_reg, mode_next;
    logic [PW-1:0]             pl_reg, pl_next;
    logic signed [CRW-1:0]     bx_reg, bx_next, by_reg, by_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [SLW-1:0]            slot_reg, slot_next;
    logic [DW-1:0]             sd_reg [NEIGHBORS];
    logic [DW-1:0]             sd_next [NEIGHBORS];
    logic signed [CRW-1:0]     tx_reg [NEIGHBORS];
    logic signed [CRW-1:0]     tx_next [NEIGHBORS];
    logic signed [CRW-1:0]     ty_reg [NEIGHBORS];
    logic signed [CRW-1:0]     ty_next [NEIGHBORS];
    logic [33:0]               acc_reg, acc_next;
    logic [DW-1:0]             best_reg, best_next;
    logic signed [CRW-1:0]     brx_reg, brx_next, bry_reg, bry_next;

    // Log, weight and sum registers.
    logic [kip_pkg::LOG_W-1:0]  lg_reg [NEIGHBORS];
    logic [kip_pkg::LOG_W-1:0]  lg_next [NEIGHBORS];
    logic [kip_pkg::LOG_W-1:0]  lmin_reg, lmin_next;
    logic [DW-1:0]              norm_reg, norm_next;
    logic [kip_pkg::NEXP_W-1:0] nexp_reg, nexp_next;
    logic [kip_pkg::MANT_W-1:0] msq_reg, msq_next;
    logic [kip_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [3:0]                 step_reg, step_next;
    logic [kip_pkg::KEXP_W-1:0] kexp_reg, kexp_next;
    logic [kip_pkg::GVAL_W-1:0] gval_reg, gval_next;
    logic [kip_pkg::POW_W-1:0]  tval_reg, tval_next;
    logic [1:0]                 hstep_reg, hstep_next;
    logic [kip_pkg::WT_W-1:0]   wt_reg, wt_next;
    logic [kip_pkg::DEN_W-1:0]  den_reg, den_next;
    logic signed [kip_pkg::NUM_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic                       divc_reg, divc_next;
    logic [1:0]                 rstat_reg, rstat_next;
    logic signed [CRW-1:0]      resx_reg, resx_next, resy_reg, resy_next;
    logic [1:0]                 ostat_reg, ostat_next;
    logic signed [CRW-1:0]      ox_reg, ox_next, oy_reg, oy_next;

    // Shared multiplier.
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [2*MW-1:0]     prod_reg, prod_next;

    // Divider link.
    kip_pkg::div_req_t          div_req;
    kip_pkg::div_rsp_t          div_rsp;

    // Helpers.
    logic                       accept;
    logic                       pl_ok;
    logic [CW-1:0]              cnt_cur;
    logic signed [CRW:0]        dx, dy;
    logic [DW-1:0]              d_cur;
    logic [NEIGHBORS-1:0]       lt;
    logic                       qualifies;
    logic [32:0]                sq_top;
    logic [kip_pkg::FRAC_W-1:0] frac_new;
    logic [kip_pkg::LOG_W-1:0]  lg_new;
    logic [29:0]                nq_full;
    logic [kip_pkg::LOG_W-1:0]  lg_diff;
    logic [kip_pkg::POW_W-1:0]  coef;

    kip_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Handshake and port outputs.
    assign item_stall   = (st_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign status       = ostat_reg;
    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;

    // Table lookup for the addressed player.
    always_comb
    begin
        pl_ok   = (int'(player) < PLAYERS);
        cnt_cur = pl_ok ? count_reg[player[PW-1:0]] : '0;
    end

    // Scan arithmetic on the word read for the current index.
    always_comb
    begin
        dx    = $signed({rd_word_reg[CRW-1], rd_word_reg[CRW-1:0]})
              - $signed({bx_reg[CRW-1], bx_reg});
        dy    = $signed({rd_word_reg[2*CRW-1], rd_word_reg[2*CRW-1:CRW]})
              - $signed({by_reg[CRW-1], by_reg});
        d_cur = DW'(acc_reg) + DW'(prod_reg[33:0]);
        for (int j = 0; j < NEIGHBORS; j++)
        begin
            lt[j] = (d_cur < sd_reg[j]);
        end
        qualifies = lt[NEIGHBORS-1] && (d_cur >= kip_pkg::NEAR_D2_MIN);
    end

    // Log step, weight exponent and cubic coefficient.
    always_comb
    begin
        sq_top   = prod_reg[63:31];
        frac_new = sq_top[32] ? {frac_reg[kip_pkg::FRAC_W-2:0], 1'b1}
                              : {frac_reg[kip_pkg::FRAC_W-2:0], 1'b0};
        lg_new   = {nexp_reg, frac_new};
        lg_diff  = lg_reg[slot_reg] - lmin_reg;
        nq_full  = {1'b0, prod_reg[28:0]} + 30'd16;
        case (hstep_reg)
            2'd0:    coef = kip_pkg::EXP_C2;
            2'd1:    coef = kip_pkg::EXP_C1;
            default: coef = kip_pkg::EXP_C0;
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            S_SC_DX:
            begin
                mul_a = MW'(dx);
                mul_b = MW'(dx);
            end
            S_SC_DY:
            begin
                mul_a = MW'(dy);
                mul_b = MW'(dy);
            end
            S_LG_SQ:
            begin
                mul_a = $signed({1'b0, msq_reg});
                mul_b = $signed({1'b0, msq_reg});
            end
            S_WT_N:
            begin
                mul_a = $signed(MW'(wexp_reg));
                mul_b = $signed(MW'(lg_diff));
            end
            S_WT_HM:
            begin
                mul_a = $signed(MW'(tval_reg));
                mul_b = $signed(MW'(gval_reg));
            end
            S_WT_MX:
            begin
                mul_a = $signed({1'b0, wt_reg});
                mul_b = MW'(tx_reg[slot_reg]);
            end
            S_WT_MY:
            begin
                mul_a = $signed({1'b0, wt_reg});
                mul_b = MW'(ty_reg[slot_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        st_next        = st_reg;
        count_next     = count_reg;
        wexp_next      = (cfg_valid && cfg_ready) ? weight_exponent : wexp_reg;
        out_valid_next = out_valid_reg && result_stall;
        mode_next      = mode_reg;
        pl_next        = pl_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        sd_next        = sd_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        lg_next        = lg_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        brx_next       = brx_reg;
        bry_next       = bry_reg;
        lmin_next      = lmin_reg;
        norm_next      = norm_reg;
        nexp_next      = nexp_reg;
        msq_next       = msq_reg;
        frac_next      = frac_reg;
        step_next      = step_reg;
        kexp_next      = kexp_reg;
        gval_next      = gval_reg;
        tval_next      = tval_reg;
        hstep_next     = hstep_reg;
        wt_next        = wt_reg;
        den_next       = den_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        divc_next      = divc_reg;
        rstat_next     = rstat_reg;
        resx_next      = resx_reg;
        resy_next      = resy_reg;
        ostat_next     = ostat_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        mem_we         = 1'b0;
        wr_addr        = {player[PW-1:0], cnt_cur[SW-1:0]};
        wr_word        = {target_y, target_x, ball_y, ball_x};
        div_req.start  = 1'b0;
        div_req.num    = divc_reg ? ny_reg : nx_reg;
        div_req.den    = den_reg;

        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    pl_next   = player[PW-1:0];
                    bx_next   = ball_x;
                    by_next   = ball_y;
                    cnt_next  = cnt_cur;
                    idx_next  = '0;
                    slot_next = '0;
                    best_next = kip_pkg::FAR_D2;
                    brx_next  = '0;
                    bry_next  = '0;
                    den_next  = '0;
                    nx_next   = '0;
                    ny_next   = '0;
                    divc_next = 1'b0;
                    resx_next = '0;
                    resy_next = '0;
                    rstat_next = kip_pkg::STAT_ANSWER;
                    for (int j = 0; j < NEIGHBORS; j++)
                    begin
                        sd_next[j] = kip_pkg::FAR_D2;
                        tx_next[j] = '0;
                        ty_next[j] = '0;
                    end
                    case (mode)
                        kip_pkg::MODE_LOAD:
                        begin
                            if (pl_ok && (cnt_cur < CW'(SAMPLES)))
                            begin
                                mem_we = 1'b1;
                                count_next[player[PW-1:0]] = cnt_cur + CW'(1);
                                rstat_next = kip_pkg::STAT_STORED;
                            end
                            else
                            begin
                                rstat_next = kip_pkg::STAT_DROPPED;
                            end
                            st_next = S_FIN;
                        end
                        kip_pkg::MODE_WEIGHTED, kip_pkg::MODE_NEAREST:
                        begin
                            st_next = (cnt_cur == '0) ? S_POST : S_SC_DX;
                        end
                        default:
                        begin
                            st_next = S_FIN;
                        end
                    endcase
                end
            end

            // Distance of one stored sample: dx squared, then dy squared.
            S_SC_DX:
            begin
                st_next = S_SC_DY;
            end
            S_SC_DY:
            begin
                acc_next = prod_reg[33:0];
                st_next  = S_SC_INS;
            end

            // Keep the sorted neighbor list or the best sample, then move on.
            S_SC_INS:
            begin
                if (mode_reg == kip_pkg::MODE_NEAREST)
                begin
                    if (d_cur < best_reg)
                    begin
                        best_next = d_cur;
                        brx_next  = rd_word_reg[3*CRW-1:2*CRW];
                        bry_next  = rd_word_reg[4*CRW-1:3*CRW];
                    end
                end
                else if (qualifies)
                begin
                    if (lt[0])
                    begin
                        sd_next[0] = d_cur;
                        tx_next[0] = rd_word_reg[3*CRW-1:2*CRW];
                        ty_next[0] = rd_word_reg[4*CRW-1:3*CRW];
                    end
                    for (int j = 1; j < NEIGHBORS; j++)
                    begin
                        if (lt[j])
                        begin
                            if (!lt[j-1])
                            begin
                                sd_next[j] = d_cur;
                                tx_next[j] = rd_word_reg[3*CRW-1:2*CRW];
                                ty_next[j] = rd_word_reg[4*CRW-1:3*CRW];
                            end
                            else
                            begin
                                sd_next[j] = sd_reg[j-1];
                                tx_next[j] = tx_reg[j-1];
                                ty_next[j] = ty_reg[j-1];
                            end
                        end
                    end
                end
                idx_next = idx_reg + CW'(1);
                st_next  = ((idx_reg + CW'(1)) == cnt_reg) ? S_POST : S_SC_DX;
            end

            S_POST:
            begin
                if (mode_reg == kip_pkg::MODE_NEAREST)
                begin
                    resx_next  = brx_reg;
                    resy_next  = bry_reg;
                    rstat_next = kip_pkg::STAT_ANSWER;
                    st_next    = S_FIN;
                end
                else
                begin
                    slot_next = '0;
                    st_next   = S_LG_INIT;
                end
            end

            // log2 of one neighbor distance: normalize, then square and compare.
            S_LG_INIT:
            begin
                norm_next = (sd_reg[slot_reg] == '0) ? DW'(1) : sd_reg[slot_reg];
                nexp_next = kip_pkg::NEXP_W'(DW - 1);
                st_next   = S_LG_NORM;
            end
            S_LG_NORM:
            begin
                if (norm_reg[DW-1] || (nexp_reg == '0))
                begin
                    msq_next  = norm_reg[DW-1:DW-kip_pkg::MANT_W];
                    frac_next = '0;
                    step_next = '0;
                    st_next   = S_LG_SQ;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    nexp_next = nexp_reg - kip_pkg::NEXP_W'(1);
                end
            end
            S_LG_SQ:
            begin
                st_next = S_LG_CHK;
            end
            S_LG_CHK:
            begin
                msq_next  = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                frac_next = frac_new;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(kip_pkg::LOG_STEPS - 1))
                begin
                    lg_next[slot_reg] = lg_new;
                    if ((slot_reg == '0) || (lg_new < lmin_reg))
                    begin
                        lmin_next = lg_new;
                    end
                    if (slot_reg == SLW'(NEIGHBORS - 1))
                    begin
                        slot_next = '0;
                        st_next   = S_WT_N;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLW'(1);
                        st_next   = S_LG_INIT;
                    end
                end
                else
                begin
                    st_next = S_LG_SQ;
                end
            end

            // Weight of one neighbor: exponent, power cubic, shift, weighted sums.
            S_WT_N:
            begin
                st_next = S_WT_G;
            end
            S_WT_G:
            begin
                kexp_next  = nq_full[29:21];
                gval_next  = 17'd65536 - {1'b0, nq_full[20:5]};
                tval_next  = kip_pkg::EXP_C3;
                hstep_next = '0;
                st_next    = S_WT_HM;
            end
            S_WT_HM:
            begin
                st_next = S_WT_HA;
            end
            S_WT_HA:
            begin
                tval_next = kip_pkg::POW_W'(coef + kip_pkg::POW_W'(prod_reg[34:16]));
                if (hstep_reg == 2'd2)
                begin
                    st_next = S_WT_SH;
                end
                else
                begin
                    hstep_next = hstep_reg + 2'd1;
                    st_next    = S_WT_HM;
                end
            end
            S_WT_SH:
            begin
                if (kexp_reg >= kip_pkg::KEXP_W'(62))
                begin
                    wt_next = '0;
                end
                else
                begin
                    wt_next = {tval_reg, 14'b0} >> (kexp_reg + kip_pkg::KEXP_W'(1));
                end
                den_next = den_reg + kip_pkg::DEN_W'(wt_next);
                st_next  = S_WT_MX;
            end
            S_WT_MX:
            begin
                st_next = S_WT_MY;
            end
            S_WT_MY:
            begin
                nx_next = nx_reg + $signed(prod_reg[kip_pkg::NUM_W-1:0]);
                st_next = S_WT_AY;
            end
            S_WT_AY:
            begin
                ny_next = ny_reg + $signed(prod_reg[kip_pkg::NUM_W-1:0]);
                if (slot_reg == SLW'(NEIGHBORS - 1))
                begin
                    st_next = S_DIV_GO;
                end
                else
                begin
                    slot_next = slot_reg + SLW'(1);
                    st_next   = S_WT_N;
                end
            end

            // Two divisions on the shared divider, x first.
            S_DIV_GO:
            begin
                div_req.start = 1'b1;
                st_next       = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!divc_reg)
                    begin
                        resx_next = div_rsp.quot;
                        divc_next = 1'b1;
                        st_next   = S_DIV_GO;
                    end
                    else
                    begin
                        resy_next  = div_rsp.quot;
                        rstat_next = kip_pkg::STAT_ANSWER;
                        st_next    = S_FIN;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = rstat_reg;
                    ox_next        = resx_reg;
                    oy_next        = resy_reg;
                    st_next        = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        rd_addr = {pl_next, idx_next[SW-1:0]};
    end

    // Sample memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            wexp_reg      <= kip_pkg::WEXP_RESET;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PLAYERS; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else
        begin
            st_reg        <= st_next;
            wexp_reg      <= wexp_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        pl_reg    <= pl_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        sd_reg    <= sd_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        lg_reg    <= lg_next;
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        brx_reg   <= brx_next;
        bry_reg   <= bry_next;
        lmin_reg  <= lmin_next;
        norm_reg  <= norm_next;
        nexp_reg  <= nexp_next;
        msq_reg   <= msq_next;
        frac_reg  <= frac_next;
        step_reg  <= step_next;
        kexp_reg  <= kexp_next;
        gval_reg  <= gval_next;
        tval_reg  <= tval_next;
        hstep_reg <= hstep_next;
        wt_reg    <= wt_next;
        den_reg   <= den_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        divc_reg  <= divc_next;
        rstat_reg <= rstat_next;
        resx_reg  <= resx_next;
        resy_reg  <= resy_next;
        ostat_reg <= ostat_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        prod_reg  <= prod_next;
    end

endmodule

FILE: hw/rtl/kip_chk.sv
// Port checker for the position lookup and its bind to the top level.
`include "assert_macros.svh"

module kip_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [kip_pkg::WEXP_W-1:0]         weight_exponent,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic [1:0]                         mode,
    input logic [3:0]                         player,
    input logic signed [kip_pkg::COORD_W-1:0] ball_x,
    input logic signed [kip_pkg::COORD_W-1:0] ball_y,
    input logic signed [kip_pkg::COORD_W-1:0] target_x,
    input logic signed [kip_pkg::COORD_W-1:0] target_y,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [1:0]                         status,
    input logic signed [kip_pkg::COORD_W-1:0] pos_x,
    input logic signed [kip_pkg::COORD_W-1:0] pos_y
);

    // A stalled result stays offered and unchanged.
    `KIP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(status) && $stable(pos_x) && $stable(pos_y))

    // After a transfer in, the block is busy with that item.
    `KIP_ASSERT_NEXT(a_busy_after_item, clk, rst_n, item_valid && !item_stall, item_stall)

    // A new result appears together with the block going free.
    `KIP_ASSERT_NOW(a_free_with_result, clk, rst_n, $rose(result_valid), !item_stall)

    // Load results carry a zero position.
    `KIP_ASSERT_NOW(a_load_zero_pos, clk, rst_n, result_valid && (status != kip_pkg::STAT_ANSWER), (pos_x == '0) && (pos_y == '0))

endmodule

bind knn_idw_position_lookup kip_chk u_kip_chk (.*);
